/* design/ecp_pkg.sv */
// Shared package for the enhanced clock page replacement block.
// Holds default sizes, register constants and the controller/datapath structs.
// No dependencies.
package ecp_pkg;

    localparam int NUM_FRAMES_DEF = 4;
    localparam int PAGE_BITS_DEF  = 20;

    localparam int CFG_W   = 3;
    localparam int FRAME_W = 2;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 3'd4;

    typedef struct packed {
        logic idle;
        logic look;
        logic sweep_init;
        logic sweep;
        logic vread;
        logic hit_commit;
        logic miss_commit;
    } ecp_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic lk_match;
        logic lk_done;
        logic sw_end;
        logic out_free;
    } ecp_status_t;

endpackage

/* design/ecp_if.sv */
// Channel interfaces for the page reference and the replacement result.
// Depends on ecp_pkg for default widths.
interface ecp_req_if
    import ecp_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;
    logic                 is_write;

    modport source (output valid, output page_number, output is_write, input ready);
    modport sink (input valid, input page_number, input is_write, output ready);
endinterface

interface ecp_resp_if
    import ecp_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [FRAME_W-1:0]   frame_index;
    logic                 victim_valid;
    logic [PAGE_BITS-1:0] victim_page;
    logic                 victim_dirty;

    modport source (output valid, output hit, output frame_index, output victim_valid,
                    output victim_page, output victim_dirty, input ready);
    modport sink (input valid, input hit, input frame_index, input victim_valid,
                  input victim_page, input victim_dirty, output ready);
endinterface

/* design/ecp_ctrl.sv */
// Controller state machine for the enhanced clock page replacement block.
// Sequences lookup, sweep, victim read and commit; depends on ecp_pkg.
module ecp_ctrl
    import ecp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ecp_status_t status,
    output ecp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_VREAD = 3'd3;
    localparam logic [2:0] S_MISS  = 3'd4;
    localparam logic [2:0] S_HIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (status.in_fire)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (status.lk_match)
                begin
                    state_next = S_HIT;
                end
                else if (status.lk_done)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sw_end)
                begin
                    state_next = S_VREAD;
                end
            end
            S_VREAD:
            begin
                cmd.vread  = 1'b1;
                state_next = S_MISS;
            end
            S_MISS:
            begin
                if (status.out_free)
                begin
                    cmd.miss_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_HIT:
            begin
                if (status.out_free)
                begin
                    cmd.hit_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/ecp_dp.sv */
// Datapath for the enhanced clock page replacement block: frame table,
// clock hand, scan counters and result register. Depends on ecp_pkg and ecp_if.
module ecp_dp
    import ecp_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    ecp_req_if.sink           req,
    ecp_resp_if.source        resp,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  ecp_cmd_t          cmd,
    output ecp_status_t       status
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);

    logic [CFG_W-1:0]      cfg_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic                  wr_reg;
    logic [CNT_W-1:0]      ring_n_reg, ring_n_next, ring_n_cfg;
    logic [IDX_W-1:0]      start_reg, start_next;
    logic [IDX_W-1:0]      hand_reg, hand_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]            pass_reg, pass_next;
    logic                  iss_done_reg, iss_done_next;
    logic [IDX_W-1:0]      sel_reg, sel_next;
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [NUM_FRAMES-1:0] use_reg, use_next;
    logic [NUM_FRAMES-1:0] mod_reg, mod_next;

    logic [PAGE_BITS-1:0]  page_mem [NUM_FRAMES];
    logic [PAGE_BITS-1:0]  rd_page_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg, rd_last_reg;
    logic                  rd_en, issue;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;

    logic                  resp_valid_reg;
    logic                  hit_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic                  vvalid_reg;
    logic [PAGE_BITS-1:0]  vpage_reg;
    logic                  vdirty_reg;

    logic                  in_fire, last_idx, last_step, sw_hit, sw_fail, sel_last;

    assign req.ready         = cmd.idle;
    assign in_fire           = req.valid && cmd.idle;
    assign resp.valid        = resp_valid_reg;
    assign resp.hit          = hit_reg;
    assign resp.frame_index  = frame_reg;
    assign resp.victim_valid = vvalid_reg;
    assign resp.victim_page  = vpage_reg;
    assign resp.victim_dirty = vdirty_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            ring_n_cfg = CNT_W'(1);
        end
        else if (32'(cfg_reg) > NUM_FRAMES)
        begin
            ring_n_cfg = CNT_W'(NUM_FRAMES);
        end
        else
        begin
            ring_n_cfg = CNT_W'(cfg_reg);
        end
    end

    assign issue     = cmd.look && !iss_done_reg;
    assign rd_en     = issue || cmd.vread;
    assign rd_addr   = cmd.vread ? sel_reg : idx_reg;
    assign mem_we    = cmd.miss_commit;
    assign last_idx  = (32'(idx_reg) == 32'(ring_n_reg) - 1);
    assign last_step = (32'(cnt_reg) == 32'(ring_n_reg) - 1);
    assign sel_last  = (32'(sel_reg) == 32'(ring_n_reg) - 1);
    assign sw_hit    = !use_reg[idx_reg] && (mod_reg[idx_reg] == pass_reg[0]);
    assign sw_fail   = last_step && (pass_reg == 2'd3);

    assign status.in_fire  = in_fire;
    assign status.lk_match = rd_vld_reg && valid_reg[rd_idx_reg] && (rd_page_reg == page_reg);
    assign status.lk_done  = rd_vld_reg && rd_last_reg;
    assign status.sw_end   = sw_hit || sw_fail;
    assign status.out_free = !resp_valid_reg || resp.ready;

    always_comb
    begin
        ring_n_next   = ring_n_reg;
        start_next    = start_reg;
        hand_next     = hand_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        pass_next     = pass_reg;
        iss_done_next = iss_done_reg;
        sel_next      = sel_reg;
        valid_next    = valid_reg;
        use_next      = use_reg;
        mod_next      = mod_reg;

        if (in_fire)
        begin
            ring_n_next   = ring_n_cfg;
            start_next    = (32'(hand_reg) < 32'(ring_n_cfg)) ? hand_reg : '0;
            idx_next      = '0;
            iss_done_next = 1'b0;
        end

        if (issue)
        begin
            if (last_idx)
            begin
                iss_done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.look && status.lk_match)
        begin
            sel_next = rd_idx_reg;
        end

        if (cmd.sweep_init)
        begin
            idx_next  = start_reg;
            cnt_next  = '0;
            pass_next = 2'd0;
        end

        if (cmd.sweep)
        begin
            if (sw_hit)
            begin
                sel_next = idx_reg;
            end
            else
            begin
                if (pass_reg[0])
                begin
                    use_next[idx_reg] = 1'b0;
                end
                if (sw_fail)
                begin
                    sel_next = start_reg;
                end
                idx_next = last_idx ? '0 : idx_reg + 1'b1;
                if (last_step)
                begin
                    cnt_next  = '0;
                    pass_next = pass_reg + 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end

        if (cmd.hit_commit)
        begin
            use_next[sel_reg] = 1'b1;
            if (wr_reg)
            begin
                mod_next[sel_reg] = 1'b1;
            end
        end

        if (cmd.miss_commit)
        begin
            valid_next[sel_reg] = 1'b1;
            use_next[sel_reg]   = 1'b1;
            mod_next[sel_reg]   = wr_reg;
            hand_next           = sel_last ? '0 : sel_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_FRAMES_RESET;
            ring_n_reg     <= CNT_W'(NUM_FRAMES);
            start_reg      <= '0;
            hand_reg       <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pass_reg       <= 2'd0;
            iss_done_reg   <= 1'b0;
            sel_reg        <= '0;
            valid_reg      <= '0;
            use_reg        <= '0;
            mod_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            ring_n_reg   <= ring_n_next;
            start_reg    <= start_next;
            hand_reg     <= hand_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            pass_reg     <= pass_next;
            iss_done_reg <= iss_done_next;
            sel_reg      <= sel_next;
            valid_reg    <= valid_next;
            use_reg      <= use_next;
            mod_reg      <= mod_next;
            rd_vld_reg   <= issue;
            rd_last_reg  <= issue && last_idx;
            if (cmd.hit_commit || cmd.miss_commit)
            begin
                resp_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            page_reg <= req.page_number;
            wr_reg   <= req.is_write;
        end
        if (issue)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (rd_en)
        begin
            rd_page_reg <= page_mem[rd_addr];
        end
        if (mem_we)
        begin
            page_mem[sel_reg] <= page_reg;
        end
        if (cmd.hit_commit)
        begin
            hit_reg    <= 1'b1;
            frame_reg  <= FRAME_W'(sel_reg);
            vvalid_reg <= 1'b0;
            vpage_reg  <= '0;
            vdirty_reg <= 1'b0;
        end
        else if (cmd.miss_commit)
        begin
            hit_reg    <= 1'b0;
            frame_reg  <= FRAME_W'(sel_reg);
            vvalid_reg <= valid_reg[sel_reg];
            vpage_reg  <= valid_reg[sel_reg] ? rd_page_reg : '0;
            vdirty_reg <= valid_reg[sel_reg] && mod_reg[sel_reg];
        end
    end

    // The hand always lands inside the ring after a replacement.
    a_hand_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.miss_commit |=> (32'(hand_reg) < 32'(ring_n_reg)))
        else $error("clock hand left the ring after a replacement");

    // A loaded frame is valid and recently used.
    a_victim_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.miss_commit |=> (valid_reg[$past(sel_reg)] && use_reg[$past(sel_reg)]))
        else $error("replaced frame not marked valid and used");

    // A result without a displaced page reports a zero victim page.
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid_reg && !vvalid_reg) |-> ((vpage_reg == '0) && !vdirty_reg))
        else $error("victim fields set without a displaced page");

endmodule

/* design/enhanced_clock_page_replacement.sv */
// Enhanced second-chance clock page replacement, top level.
// The lookup reads one frame per cycle and a hit ends it early; a miss runs the full lookup,
// then the sweep examines one frame per cycle, then the victim page is read and committed.
// One reference at a time; the result register lets the next transaction be accepted.
// Asynchronous active-low reset empties all frames, zeroes the hand and sets the configured ring size to 4.
module enhanced_clock_page_replacement
    import ecp_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    ecp_req_if.sink          req,
    ecp_resp_if.source       resp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    ecp_cmd_t    cmd;
    ecp_status_t status;

    ecp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ecp_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .resp      (resp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
